// ===== rtl/kdpq_pkg.sv =====
// shared types, constants and ordering function for the keyed deadline queue
package kdpq_pkg;

    localparam int KDPQ_CAPACITY = 64;
    localparam int NODE_W        = 32;
    localparam int PAIR_W        = 32;
    localparam int DL_W          = 64;

    localparam logic MODE_SET = 1'b0;
    localparam logic MODE_DEL = 1'b1;

    // one table entry
    typedef struct packed {
        logic [NODE_W-1:0]      node;
        logic [PAIR_W-1:0]      pair;
        logic signed [DL_W-1:0] deadline;
    } t_entry;

    // commands from controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_status;

    // true when entry a is ordered before entry b
    function automatic logic f_earlier(input t_entry a, input t_entry b,
                                       input logic [PAIR_W-1:0] soa);
        logic a_soa;
        logic b_soa;
        a_soa = (a.pair == soa);
        b_soa = (b.pair == soa);
        if (a.deadline != b.deadline) begin
            return a.deadline < b.deadline;
        end else if (a_soa != b_soa) begin
            return !a_soa;
        end else if (a.node != b.node) begin
            return a.node < b.node;
        end else begin
            return a.pair < b.pair;
        end
    endfunction

endpackage

// ===== rtl/kdpq_ctrl.sv =====
// controller state machine: accept, scan, drain, commit
module kdpq_ctrl
    import kdpq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_APPLY = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // input side is open only between operations
    assign o_in_stall = (r_state != S_IDLE);

    // commands
    always_comb begin
        o_cmd.start  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_APPLY) && i_status.out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/kdpq_dp.sv =====
// datapath: slot table, scan for key, free slot and head, result register
module kdpq_dp
    import kdpq_pkg::*;
#(
    parameter int CAPACITY = KDPQ_CAPACITY
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic                   i_cfg_wr_en,
    input  logic [PAIR_W-1:0]      i_cfg_wr_data,
    input  logic                   i_mode,
    input  logic [NODE_W-1:0]      i_node_id,
    input  logic [PAIR_W-1:0]      i_type_pair,
    input  logic signed [DL_W-1:0] i_new_deadline,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_was_scheduled,
    output logic signed [DL_W-1:0] o_old_deadline,
    output logic                   o_dropped_full,
    output logic                   o_head_valid,
    output logic [NODE_W-1:0]      o_head_node,
    output logic [PAIR_W-1:0]      o_head_pair,
    output logic signed [DL_W-1:0] o_head_deadline
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // table storage
    t_entry                r_mem [CAPACITY];
    logic [CAPACITY-1:0]   r_used;
    logic [PAIR_W-1:0]     r_soa;

    // latched operation
    logic                  r_op_mode;
    t_entry                r_op;

    // scan pipeline
    logic [AW-1:0]         r_cnt;
    logic                  r_p_vld;
    logic [AW-1:0]         r_p_idx;
    logic                  r_p_used;
    t_entry                r_p_ent;

    // scan results
    logic                  r_hit;
    logic [AW-1:0]         r_hit_idx;
    logic signed [DL_W-1:0] r_old;
    logic                  r_free_vld;
    logic [AW-1:0]         r_free_idx;
    logic                  r_best_vld;
    t_entry                r_best;

    // result register
    logic                  r_out_valid;
    logic                  r_out_was;
    logic signed [DL_W-1:0] r_out_old;
    logic                  r_out_drop;
    logic                  r_out_hvld;
    t_entry                r_out_head;

    // commit decode
    logic                  c_set_hit;
    logic                  c_del_hit;
    logic                  c_insert;
    logic                  c_dropped;
    logic                  c_cand;
    logic                  c_take_op;
    logic                  c_head_vld;
    t_entry                c_head;
    logic                  c_wr;
    logic [AW-1:0]         c_wr_idx;
    logic                  p_match;

    assign o_status.scan_last = (r_cnt == AW'(CAPACITY - 1));
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign p_match = (r_p_ent.node == r_op.node) && (r_p_ent.pair == r_op.pair);

    // decode the operation once the scan is complete
    always_comb begin
        c_set_hit  = r_hit && (r_op_mode == MODE_SET);
        c_del_hit  = r_hit && (r_op_mode == MODE_DEL);
        c_insert   = !r_hit && (r_op_mode == MODE_SET) && r_free_vld;
        c_dropped  = !r_hit && (r_op_mode == MODE_SET) && !r_free_vld;
        c_cand     = c_set_hit || c_insert;
        c_take_op  = c_cand && (!r_best_vld || f_earlier(r_op, r_best, r_soa));
        c_head_vld = c_cand || r_best_vld;
        c_head     = c_take_op ? r_op : r_best;
        if (!c_head_vld) c_head = '0;
        c_wr       = c_cand;
        c_wr_idx   = r_hit ? r_hit_idx : r_free_idx;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soa <= '0;
        end else if (i_cfg_wr_en) begin
            r_soa <= i_cfg_wr_data;
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && c_wr) begin
            r_mem[c_wr_idx] <= r_op;
        end
        if (i_cmd.scan) begin
            r_p_ent <= r_mem[r_cnt];
        end
    end

    // occupancy bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.commit) begin
            if (c_insert) r_used[r_free_idx] <= 1'b1;
            if (c_del_hit) r_used[r_hit_idx] <= 1'b0;
        end
    end

    // latch the operation on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op_mode      <= i_mode;
            r_op.node      <= i_node_id;
            r_op.pair      <= i_type_pair;
            r_op.deadline  <= i_new_deadline;
        end
    end

    // address counter and read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_cmd.scan;
            if (i_cmd.start) begin
                r_cnt <= '0;
            end else if (i_cmd.scan) begin
                r_cnt    <= r_cnt + AW'(1);
                r_p_idx  <= r_cnt;
                r_p_used <= r_used[r_cnt];
            end
        end
    end

    // compare stage: key match, first free slot, running minimum of the others
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit      <= 1'b0;
            r_free_vld <= 1'b0;
            r_best_vld <= 1'b0;
        end else if (i_cmd.start) begin
            r_hit      <= 1'b0;
            r_free_vld <= 1'b0;
            r_best_vld <= 1'b0;
        end else if (r_p_vld) begin
            if (r_p_used) begin
                if (p_match) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_p_idx;
                    r_old     <= r_p_ent.deadline;
                end else if (!r_best_vld || f_earlier(r_p_ent, r_best, r_soa)) begin
                    r_best_vld <= 1'b1;
                    r_best     <= r_p_ent;
                end
            end else if (!r_free_vld) begin
                r_free_vld <= 1'b1;
                r_free_idx <= r_p_idx;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_was  <= r_hit;
            r_out_old  <= r_hit ? r_old : '0;
            r_out_drop <= c_dropped;
            r_out_hvld <= c_head_vld;
            r_out_head <= c_head;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_was_scheduled = r_out_was;
    assign o_old_deadline  = r_out_old;
    assign o_dropped_full  = r_out_drop;
    assign o_head_valid    = r_out_hvld;
    assign o_head_node     = r_out_head.node;
    assign o_head_pair     = r_out_head.pair;
    assign o_head_deadline = r_out_head.deadline;

endmodule

// ===== rtl/keyed_deadline_priority_queue.sv =====
// top level of the keyed deadline priority queue
// Keyed min-priority queue of signed 64-bit deadlines, keyed by node id
// and type pair. Input channel (i_in_valid / o_in_stall) carries one
// operation per transfer: set or update a deadline, or delete the entry.
// Output channel (o_out_valid / i_out_stall) returns one result per
// operation: previous state of the key, a table-full drop flag, and the
// head entry after the operation.
// Each operation reads every slot of the table once through the single
// memory read port, then passes a drain step and a commit step. A new
// operation is taken only after the previous one has committed.
// A finished result waits in the output register while the next operation
// is taken and scanned; a stall on the output only holds the commit of
// the following operation until the register is free.
// i_cfg_wr_en writes the SOA pair code, which orders last among equal
// deadlines; write it only between operations.
// Reset (synchronous, active low) empties the table at once, clears the
// SOA code to zero and drops any pending result.
module keyed_deadline_priority_queue
    import kdpq_pkg::*;
#(
    parameter int CAPACITY = KDPQ_CAPACITY
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [PAIR_W-1:0]      i_cfg_wr_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_mode,
    input  logic [NODE_W-1:0]      i_node_id,
    input  logic [PAIR_W-1:0]      i_type_pair,
    input  logic signed [DL_W-1:0] i_new_deadline,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_was_scheduled,
    output logic signed [DL_W-1:0] o_old_deadline,
    output logic                   o_dropped_full,
    output logic                   o_head_valid,
    output logic [NODE_W-1:0]      o_head_node,
    output logic [PAIR_W-1:0]      o_head_pair,
    output logic signed [DL_W-1:0] o_head_deadline
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencing
    kdpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // table and result datapath
    kdpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_mode          (i_mode),
        .i_node_id       (i_node_id),
        .i_type_pair     (i_type_pair),
        .i_new_deadline  (i_new_deadline),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_was_scheduled (o_was_scheduled),
        .o_old_deadline  (o_old_deadline),
        .o_dropped_full  (o_dropped_full),
        .o_head_valid    (o_head_valid),
        .o_head_node     (o_head_node),
        .o_head_pair     (o_head_pair),
        .o_head_deadline (o_head_deadline)
    );

endmodule

// ===== dv/kdpq_checker.sv =====
// watches both channels of the keyed deadline queue, predicts each result and compares it
`timescale 1ns / 100ps
module kdpq_checker
    import kdpq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [PAIR_W-1:0]      i_cfg_wr_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic                   i_mode,
    input  logic [NODE_W-1:0]      i_node_id,
    input  logic [PAIR_W-1:0]      i_type_pair,
    input  logic signed [DL_W-1:0] i_new_deadline,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic                   i_was_scheduled,
    input  logic signed [DL_W-1:0] i_old_deadline,
    input  logic                   i_dropped_full,
    input  logic                   i_head_valid,
    input  logic [NODE_W-1:0]      i_head_node,
    input  logic [PAIR_W-1:0]      i_head_pair,
    input  logic signed [DL_W-1:0] i_head_deadline,
    output int                     o_fail_count,
    output int                     o_pending
);

    // one predicted result transfer
    typedef struct packed {
        logic                   was;
        logic signed [DL_W-1:0] old;
        logic                   dropped;
        logic                   head_ok;
        logic [NODE_W-1:0]      head_node;
        logic [PAIR_W-1:0]      head_pair;
        logic signed [DL_W-1:0] head_dl;
    } t_outcome;

    // shadow copy of the deadline table and the soa code
    logic              slot_live [KDPQ_CAPACITY];
    t_entry            slot_ent  [KDPQ_CAPACITY];
    logic [PAIR_W-1:0] soa_code;
    t_outcome          pending_results [$];
    int                fail_total = 0;

    // queue order: deadline, then non-soa pairs, then node id, then pair
    function automatic logic ranks_ahead(input t_entry a, input t_entry b);
        logic a_last;
        logic b_last;
        a_last = (a.pair == soa_code);
        b_last = (b.pair == soa_code);
        if ($signed(a.deadline) != $signed(b.deadline)) begin
            return $signed(a.deadline) < $signed(b.deadline);
        end
        if (a_last != b_last) begin
            return b_last;
        end
        if (a.node != b.node) begin
            return a.node < b.node;
        end
        return a.pair < b.pair;
    endfunction

    // apply one operation to the shadow table and build its result
    function automatic t_outcome apply_op(input logic mode, input logic [NODE_W-1:0] node,
                                          input logic [PAIR_W-1:0] pair,
                                          input logic signed [DL_W-1:0] dl);
        int       hit = -1;
        int       spare = -1;
        int       best = -1;
        t_outcome res;
        res = '0;
        for (int i = 0; i < KDPQ_CAPACITY; i++) begin
            if (slot_live[i]) begin
                if (hit < 0 && slot_ent[i].node == node && slot_ent[i].pair == pair) begin
                    hit = i;
                end
            end else if (spare < 0) begin
                spare = i;
            end
        end
        if (hit >= 0) begin
            res.was = 1'b1;
            res.old = slot_ent[hit].deadline;
            if (mode == MODE_SET) begin
                slot_ent[hit].deadline = dl;
            end else begin
                slot_live[hit] = 1'b0;
            end
        end else if (mode == MODE_SET) begin
            if (spare >= 0) begin
                slot_live[spare] = 1'b1;
                slot_ent[spare]  = '{node: node, pair: pair, deadline: dl};
            end else begin
                res.dropped = 1'b1;
            end
        end
        // find the new head
        for (int i = 0; i < KDPQ_CAPACITY; i++) begin
            if (slot_live[i] && (best < 0 || ranks_ahead(slot_ent[i], slot_ent[best]))) begin
                best = i;
            end
        end
        if (best >= 0) begin
            res.head_ok   = 1'b1;
            res.head_node = slot_ent[best].node;
            res.head_pair = slot_ent[best].pair;
            res.head_dl   = slot_ent[best].deadline;
        end
        return res;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // sample both channels and the config port at each rising edge
    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            for (int i = 0; i < KDPQ_CAPACITY; i++) begin
                slot_live[i] = 1'b0;
            end
            soa_code = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                soa_code = i_cfg_wr_data;
            end
            // result transfer: compare with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    fail_total++;
                    $display("%0t: result transfer with no operation outstanding", $time);
                end else begin
                    want = pending_results.pop_front();
                    check_field("was_scheduled", 64'(want.was), 64'(i_was_scheduled));
                    check_field("old_deadline", want.old, i_old_deadline);
                    check_field("dropped_full", 64'(want.dropped), 64'(i_dropped_full));
                    check_field("head_valid", 64'(want.head_ok), 64'(i_head_valid));
                    check_field("head_node", 64'(want.head_node), 64'(i_head_node));
                    check_field("head_pair", 64'(want.head_pair), 64'(i_head_pair));
                    check_field("head_deadline", want.head_dl, i_head_deadline);
                end
            end
            // operation transfer: predict its result
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(apply_op(i_mode, i_node_id, i_type_pair,
                                                   i_new_deadline));
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== dv/tb_top.sv =====
// stimulus and verdict for the keyed deadline queue, with the checker beside the block
`timescale 1ns / 100ps
module tb_top
    import kdpq_pkg::*;
();

    localparam int                     HOLD_CYCLES = 400;
    localparam int                     TAIL_CYCLES = 80;
    localparam longint                 TIMEOUT_NS  = 6_400_000;
    localparam logic signed [DL_W-1:0] DL_MIN      = {1'b1, {(DL_W-1){1'b0}}};
    localparam logic signed [DL_W-1:0] DL_MAX      = {1'b0, {(DL_W-1){1'b1}}};

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [PAIR_W-1:0]      i_cfg_wr_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_mode;
    logic [NODE_W-1:0]      i_node_id;
    logic [PAIR_W-1:0]      i_type_pair;
    logic signed [DL_W-1:0] i_new_deadline;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_was_scheduled;
    logic signed [DL_W-1:0] o_old_deadline;
    logic                   o_dropped_full;
    logic                   o_head_valid;
    logic [NODE_W-1:0]      o_head_node;
    logic [PAIR_W-1:0]      o_head_pair;
    logic signed [DL_W-1:0] o_head_deadline;

    int fail_count;
    int pending;
    bit quiet     = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;

    // key and deadline pools that make hits and ties common
    logic [NODE_W-1:0]      node_pool [32];
    logic [PAIR_W-1:0]      pair_pool [4];
    logic signed [DL_W-1:0] dl_pool   [8];

    keyed_deadline_priority_queue u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_node_id       (i_node_id),
        .i_type_pair     (i_type_pair),
        .i_new_deadline  (i_new_deadline),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_was_scheduled (o_was_scheduled),
        .o_old_deadline  (o_old_deadline),
        .o_dropped_full  (o_dropped_full),
        .o_head_valid    (o_head_valid),
        .o_head_node     (o_head_node),
        .o_head_pair     (o_head_pair),
        .o_head_deadline (o_head_deadline)
    );

    kdpq_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_node_id       (i_node_id),
        .i_type_pair     (i_type_pair),
        .i_new_deadline  (i_new_deadline),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_was_scheduled (o_was_scheduled),
        .i_old_deadline  (o_old_deadline),
        .i_dropped_full  (o_dropped_full),
        .i_head_valid    (o_head_valid),
        .i_head_node     (o_head_node),
        .i_head_pair     (o_head_pair),
        .i_head_deadline (o_head_deadline),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    // result side: random stall bursts, one long hold on request, none when quiet
    initial begin : result_side
        int n;
        forever begin
            if (quiet) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 12);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 40);
                i_out_stall <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic pause_in(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // offer one operation and hold it until the transfer
    task automatic issue(input logic mode, input logic [NODE_W-1:0] node,
                         input logic [PAIR_W-1:0] pair, input logic signed [DL_W-1:0] dl);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            pause_in($urandom_range(1, 12));
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_node_id      <= node;
        i_type_pair    <= pair;
        i_new_deadline <= dl;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_soa(input logic [PAIR_W-1:0] code);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= code;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // random operations over a key pool, with some fully random noise
    task automatic run_phase(input int count, input int keys, input int set_pct,
                             input int hold_at, input int pause_at);
        int                     k;
        logic                   op;
        logic signed [DL_W-1:0] dl;
        for (int idx = 0; idx < count; idx++) begin
            if (idx == hold_at) begin
                hold_req = 1'b1;
            end
            if (idx == pause_at) begin
                drain();
            end
            if ($urandom_range(0, 99) < 10) begin
                op = ($urandom_range(0, 1) == 0) ? MODE_SET : MODE_DEL;
                issue(op, $urandom, $urandom, {$urandom, $urandom});
            end else begin
                k  = $urandom_range(0, keys - 1);
                op = ($urandom_range(0, 99) < set_pct) ? MODE_SET : MODE_DEL;
                dl = ($urandom_range(0, 9) < 7) ? dl_pool[3'($urandom_range(0, 7))]
                                                : {$urandom, $urandom};
                issue(op, node_pool[5'(k >> 2)], pair_pool[2'(k & 3)], dl);
            end
        end
    endtask

    // stimulus
    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= '0;
        i_in_valid     <= 1'b0;
        i_mode         <= MODE_SET;
        i_node_id      <= '0;
        i_type_pair    <= '0;
        i_new_deadline <= '0;

        node_pool[0] = '0;
        node_pool[1] = '1;
        for (int i = 2; i < 32; i++) begin
            node_pool[i] = $urandom;
        end
        pair_pool[0] = '0;
        pair_pool[1] = '1;
        pair_pool[2] = $urandom;
        pair_pool[3] = $urandom;
        dl_pool[0] = DL_MIN;
        dl_pool[1] = DL_MAX;
        dl_pool[2] = '0;
        dl_pool[3] = -64'sd1;
        dl_pool[4] = 64'sd1;
        for (int i = 5; i < 8; i++) begin
            dl_pool[i] = {$urandom, $urandom};
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, soa code still at its reset value of zero
        issue(MODE_DEL, 32'd5, 32'd7, 64'sd0);                 // delete on empty table
        issue(MODE_SET, 32'd0, 32'd0, 64'sd0);                 // node id zero, soa pair
        issue(MODE_SET, 32'd1, 32'd3, 64'sd0);                 // tie, non-soa goes first
        issue(MODE_SET, 32'd0, 32'd0, 64'sd0);                 // same deadline again
        issue(MODE_SET, '1, '1, DL_MIN);
        issue(MODE_SET, '1, '1, DL_MAX);                       // update to latest
        issue(MODE_SET, 32'd0, 32'd1, 64'sd0);                 // tie on node id
        issue(MODE_SET, 32'd0, 32'd2, 64'sd0);                 // tie down to pair
        issue(MODE_DEL, 32'd0, 32'd1, {$urandom, $urandom});   // deadline ignored
        issue(MODE_SET, 32'd2, 32'd0, -64'sd1);                // soa pair but earlier
        issue(MODE_DEL, 32'd2, 32'd0, 64'sd0);
        issue(MODE_DEL, 32'd2, 32'd0, 64'sd0);                 // already gone
        issue(MODE_SET, 32'h8000_0000, 32'h7FFF_FFFF, 64'h8000_0000_0000_0001);
        issue(MODE_SET, 32'h8000_0000, 32'h7FFF_FFFF, DL_MAX);
        // empty the table again
        issue(MODE_DEL, 32'd0, 32'd0, DL_MAX);
        issue(MODE_DEL, 32'd1, 32'd3, DL_MIN);
        issue(MODE_DEL, '1, '1, 64'sd0);
        issue(MODE_DEL, 32'd0, 32'd2, 64'sd0);
        issue(MODE_DEL, 32'h8000_0000, 32'h7FFF_FFFF, 64'sd0);
        drain();

        // random phases, each under its own soa code
        write_soa('1);
        run_phase(200, 12, 60, -1, -1);
        drain();
        write_soa(pair_pool[2]);
        run_phase(300, 100, 90, 120, -1);                      // fills the table, long hold
        drain();
        write_soa($urandom);
        run_phase(200, 100, 40, -1, -1);
        drain();
        write_soa('0);
        run_phase(250, 100, 80, -1, 100);                      // refill, pause mid-way
        drain();
        write_soa(pair_pool[3]);
        run_phase(200, 100, 25, -1, -1);
        drain();
        write_soa(pair_pool[1]);
        run_phase(200, 20, 60, -1, -1);
        drain();
        quiet = 1'b1;
        write_soa(pair_pool[2'($urandom_range(0, 3))]);
        run_phase(180, 40, 55, -1, -1);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
